### hw/rtl/hssl_pkg.sv
// Shared types and constants for the history sample select / lerp block.
`timescale 1ns / 1ps
package hssl_pkg;

  localparam int TICK_W      = 32;
  localparam int COMP_W      = 3;
  localparam int FRAC_W      = 18;  // signed Q2.16
  localparam int DIV_STEPS   = FRAC_W;
  localparam int NUM_W       = 49;  // |diff| << 16 plus half the span
  localparam int REM_W       = 50;
  localparam int IN_TUSER_W  = 6;
  localparam int OUT_TUSER_W = 7;

  localparam logic [FRAC_W-1:0] FRAC_MAX_C = 18'h1FFFF;
  localparam logic [FRAC_W-1:0] FRAC_MIN_C = 18'h20000;

  typedef enum logic [2:0] {
    SEL_NONE   = 3'd0,
    SEL_EXACT  = 3'd1,
    SEL_CLAMP  = 3'd2,
    SEL_INTERP = 3'd3,
    SEL_OLDER  = 3'd4
  } sel_t;

  // per-request control that rides along with the arithmetic
  typedef struct packed {
    logic [COMP_W-1:0] component;
    sel_t              sel;
    logic              last;
    logic              neg;        // target tick is before tick A
    logic              zero_frac;  // tick B not after tick A
  } ctrl_t;

endpackage

### hw/rtl/hssl_front.sv
// Front end: unpacks a request and picks the selection case.
`timescale 1ns / 1ps
module hssl_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int TDATA_W     = 224
) (
  input  logic [TDATA_W-1:0]            s_tdata,
  input  logic [hssl_pkg::IN_TUSER_W-1:0] s_tuser,
  input  logic                          s_tlast,
  output hssl_pkg::ctrl_t               ctrl,
  output logic [hssl_pkg::TICK_W-1:0]   absdiff,
  output logic [hssl_pkg::TICK_W-1:0]   den,
  output logic [VALUE_WIDTH-1:0]        val_a,
  output logic [VALUE_WIDTH-1:0]        val_b
);
  import hssl_pkg::*;

  logic [TICK_W-1:0]      target, tick_a, tick_b, gen_a, gen_b;
  logic [VALUE_WIDTH-1:0] value_a, value_b;
  logic                   exact_hit, have_older, have_newer;

  assign target     = s_tdata[TICK_W-1:0];
  assign tick_a     = s_tdata[2*TICK_W-1:TICK_W];
  assign tick_b     = s_tdata[3*TICK_W-1:2*TICK_W];
  assign gen_a      = s_tdata[4*TICK_W-1:3*TICK_W];
  assign gen_b      = s_tdata[5*TICK_W-1:4*TICK_W];
  assign value_a    = s_tdata[5*TICK_W+VALUE_WIDTH-1:5*TICK_W];
  assign value_b    = s_tdata[5*TICK_W+2*VALUE_WIDTH-1:5*TICK_W+VALUE_WIDTH];
  assign exact_hit  = s_tuser[3];
  assign have_older = s_tuser[4];
  assign have_newer = s_tuser[5];

  always_comb begin
    ctrl.component = s_tuser[COMP_W-1:0];
    ctrl.last      = s_tlast;
    ctrl.neg       = target < tick_a;
    ctrl.zero_frac = !(tick_b > tick_a);
    absdiff        = ctrl.neg ? (tick_a - target) : (target - tick_a);
    den            = tick_b - tick_a;
    // non-interpolated cases carry A == B so the lerp passes the value through
    if (exact_hit && have_older) begin
      ctrl.sel = SEL_EXACT;
      val_a    = value_a;
      val_b    = value_a;
    end else if (have_older && have_newer) begin
      if (gen_a != gen_b) begin
        ctrl.sel = SEL_CLAMP;
        val_a    = value_b;
        val_b    = value_b;
      end else begin
        ctrl.sel = SEL_INTERP;
        val_a    = value_a;
        val_b    = value_b;
      end
    end else if (have_older) begin
      ctrl.sel = SEL_OLDER;
      val_a    = value_a;
      val_b    = value_a;
    end else begin
      ctrl.sel = SEL_NONE;
      val_a    = '0;
      val_b    = '0;
    end
  end

endmodule

### hw/rtl/hssl_queue.sv
// Small FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module hssl_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/hssl_back.sv
// Back end: pipelined fraction divider, lerp multiplier and output register.
`timescale 1ns / 1ps
module hssl_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hssl_pkg::ctrl_t             in_ctrl,
  input  logic [hssl_pkg::TICK_W-1:0] in_absdiff,
  input  logic [hssl_pkg::TICK_W-1:0] in_den,
  input  logic [VALUE_WIDTH-1:0]      in_val_a,
  input  logic [VALUE_WIDTH-1:0]      in_val_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hssl_pkg::ctrl_t             out_ctrl,
  output logic [hssl_pkg::FRAC_W-1:0] out_frac,
  output logic [VALUE_WIDTH-1:0]      out_value
);
  import hssl_pkg::*;

  localparam int D_W    = VALUE_WIDTH + 1;
  localparam int PROD_W = D_W + FRAC_W;
  localparam int TERM_W = PROD_W - 16;
  localparam int R_W    = VALUE_WIDTH + 4;

  logic adv;

  // divider chain, index 0 is the numerator setup stage
  logic                   vld   [0:DIV_STEPS];
  logic [REM_W-1:0]       rem   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]   quo   [0:DIV_STEPS];
  logic [TICK_W-1:0]      den_s [0:DIV_STEPS];
  logic                   ovf_s [0:DIV_STEPS];
  ctrl_t                  ctl_s [0:DIV_STEPS];
  logic [VALUE_WIDTH-1:0] va_s  [0:DIV_STEPS];
  logic [VALUE_WIDTH-1:0] vb_s  [0:DIV_STEPS];
  logic [REM_W:0]         trial [0:DIV_STEPS-1];
  logic                   ovf_in[0:DIV_STEPS-1];

  logic [NUM_W-1:0]       num;

  // fraction stage
  logic                     v_f;
  ctrl_t                    ctl_f;
  logic [VALUE_WIDTH-1:0]   va_f;
  logic signed [FRAC_W-1:0] f_f, f_next;
  logic signed [D_W-1:0]    d_f, d_next;
  logic                     big;

  // multiply stage
  logic                     v_m;
  ctrl_t                    ctl_m;
  logic [VALUE_WIDTH-1:0]   va_m;
  logic [FRAC_W-1:0]        f_m;
  logic signed [PROD_W-1:0] prod_m, prod_next;

  // result stage
  logic                     v_r;
  ctrl_t                    ctl_r;
  logic [FRAC_W-1:0]        f_r;
  logic [VALUE_WIDTH-1:0]   val_r, val_next;
  logic [PROD_W-1:0]        rsum;
  logic [TERM_W-1:0]        term;
  logic [R_W-1:0]           r_full;

  // whole pipeline moves together; the output register frees it
  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  assign num = {1'b0, in_absdiff, 16'h0000} + NUM_W'(in_den[TICK_W-1:1]);

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {1'b0, rem[k]} - {1'b0, REM_W'(den_s[k]) << (DIV_STEPS - 1 - k)};
      if (k == 0) begin
        ovf_in[k] = rem[0] >= (REM_W'(den_s[0]) << DIV_STEPS);
      end else begin
        ovf_in[k] = ovf_s[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 0; k < DIV_STEPS; k++) begin
        vld[k+1] <= vld[k];
      end
    end
    if (adv) begin
      rem[0]   <= REM_W'(num);
      quo[0]   <= '0;
      den_s[0] <= in_den;
      ovf_s[0] <= 1'b0;
      ctl_s[0] <= in_ctrl;
      va_s[0]  <= in_val_a;
      vb_s[0]  <= in_val_b;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k+1]   <= trial[k][REM_W] ? rem[k] : trial[k][REM_W-1:0];
        quo[k+1]   <= {quo[k][DIV_STEPS-2:0], ~trial[k][REM_W]};
        den_s[k+1] <= den_s[k];
        ovf_s[k+1] <= ovf_in[k];
        ctl_s[k+1] <= ctl_s[k];
        va_s[k+1]  <= va_s[k];
        vb_s[k+1]  <= vb_s[k];
      end
    end
  end

  // round-to-nearest quotient is already in quo; saturate and sign it
  always_comb begin
    big = ovf_s[DIV_STEPS] || quo[DIV_STEPS][FRAC_W-1];
    if (ctl_s[DIV_STEPS].sel != SEL_INTERP || ctl_s[DIV_STEPS].zero_frac) begin
      f_next = '0;
    end else if (ctl_s[DIV_STEPS].neg) begin
      f_next = big ? FRAC_MIN_C : -quo[DIV_STEPS];
    end else begin
      f_next = big ? FRAC_MAX_C : quo[DIV_STEPS];
    end
    d_next = {vb_s[DIV_STEPS][VALUE_WIDTH-1], vb_s[DIV_STEPS]}
           - {va_s[DIV_STEPS][VALUE_WIDTH-1], va_s[DIV_STEPS]};
  end

  assign prod_next = d_f * f_f;

  // value_a + floor((d * f + 0.5) / 1.0), saturated
  always_comb begin
    rsum   = prod_m + PROD_W'(32'd32768);
    term   = rsum[PROD_W-1:16];
    r_full = {{4{va_m[VALUE_WIDTH-1]}}, va_m}
           + {{(R_W - TERM_W){term[TERM_W-1]}}, term};
    if (r_full[R_W-1:VALUE_WIDTH-1] == '0 || r_full[R_W-1:VALUE_WIDTH-1] == '1) begin
      val_next = r_full[VALUE_WIDTH-1:0];
    end else if (r_full[R_W-1]) begin
      val_next = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    end else begin
      val_next = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
      v_m <= 1'b0;
      v_r <= 1'b0;
    end else if (adv) begin
      v_f <= vld[DIV_STEPS];
      v_m <= v_f;
      v_r <= v_m;
    end
    if (adv) begin
      ctl_f  <= ctl_s[DIV_STEPS];
      va_f   <= va_s[DIV_STEPS];
      f_f    <= f_next;
      d_f    <= d_next;
      ctl_m  <= ctl_f;
      va_m   <= va_f;
      f_m    <= f_f;
      prod_m <= prod_next;
      ctl_r  <= ctl_m;
      f_r    <= f_m;
      val_r  <= val_next;
    end
  end

  assign out_valid = v_r;
  assign out_ctrl  = ctl_r;
  assign out_frac  = f_r;
  assign out_value = val_r;

endmodule

### hw/rtl/history_sample_select_lerp.sv
// Top level: pose component selection and interpolation between two samples.
`timescale 1ns / 1ps
// Each request carries one pose component of two history samples A (older)
// and B (newer) and yields exactly one result, in request order. Selection:
// exact hit with A present gives A; A and B of different generations clamp
// to B; A and B of the same generation interpolate with fraction
// (target - tick_a) / (tick_b - tick_a) in signed Q2.16, rounded half away
// from zero and saturated, or 0 when tick B is not after tick A; A alone
// gives A; otherwise handled is 0 and all values are 0. The interpolated
// value is rounded half up and saturated to VALUE_WIDTH bits.
// Throughput is one request per clock while no result waits on m_tready.
// A request accepted into the 4-entry input queue goes on to the numerator
// setup stage, then through 18 stages of the restoring fraction divider
// (one quotient bit per stage), fraction saturation, the multiply and the
// output register, which drives m_tvalid.
// The queue keeps s_tready high while a result waits on m_tready, until its
// 4 entries are full; the arithmetic pipeline itself stalls as a whole.
module history_sample_select_lerp #(
  parameter int VALUE_WIDTH = 32,
  localparam int IN_TDATA_W  = ((5 * hssl_pkg::TICK_W + 2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((hssl_pkg::FRAC_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_tick, tick_a, tick_b, gen_a, gen_b, value_a, value_b, zero pad
  input  logic [IN_TDATA_W-1:0]            s_tdata,
  // component[2:0], exact_hit, have_older, have_newer
  input  logic [hssl_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                             s_tlast,   // final_component
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fraction[17:0], value_out, zero pad
  output logic [OUT_TDATA_W-1:0]           m_tdata,
  // component_out[2:0], handled, selection[2:0]
  output logic [hssl_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic                             m_tlast    // final_out
);
  import hssl_pkg::*;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] val_b;
    logic [VALUE_WIDTH-1:0] val_a;
    logic [TICK_W-1:0]      den;
    logic [TICK_W-1:0]      absdiff;
    ctrl_t                  ctrl;
  } q_item_t;

  localparam int Q_DEPTH = 4;

  q_item_t                f_item, q_item;
  logic                   q_valid, q_ready;
  ctrl_t                  out_ctrl;
  logic [FRAC_W-1:0]      out_frac;
  logic [VALUE_WIDTH-1:0] out_value;

  // classify the request on its way into the queue
  hssl_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TDATA_W     (IN_TDATA_W)
  ) u_front (
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .ctrl    (f_item.ctrl),
    .absdiff (f_item.absdiff),
    .den     (f_item.den),
    .val_a   (f_item.val_a),
    .val_b   (f_item.val_b)
  );

  hssl_queue #(
    .WIDTH ($bits(q_item_t)),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_tvalid),
    .wr_ready (s_tready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  // divider, multiplier and the output register
  hssl_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_ctrl    (q_item.ctrl),
    .in_absdiff (q_item.absdiff),
    .in_den     (q_item.den),
    .in_val_a   (q_item.val_a),
    .in_val_b   (q_item.val_b),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ctrl   (out_ctrl),
    .out_frac   (out_frac),
    .out_value  (out_value)
  );

  assign m_tdata = OUT_TDATA_W'({out_value, out_frac});
  assign m_tuser = {out_ctrl.sel, out_ctrl.sel != SEL_NONE, out_ctrl.component};
  assign m_tlast = out_ctrl.last;

endmodule
